### design/fccm_pkg.sv
// ----------------------------------------------------------------------------
// fccm_pkg - cluster chain manager shared types
// Request and response payloads, request codes and register map.
// ----------------------------------------------------------------------------
package fccm_pkg;

    // request codes
    localparam logic [2:0] REQ_READ     = 3'd0;
    localparam logic [2:0] REQ_ALLOC    = 3'd1;
    localparam logic [2:0] REQ_RESIZE   = 3'd2;
    localparam logic [2:0] REQ_FREE     = 3'd3;
    localparam logic [2:0] REQ_TRUNCATE = 3'd4;

    // configuration register map
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SHIFT = 2'd2;

    localparam logic [15:0] RST_END_MARKER    = 16'hFFFF;
    localparam logic [15:0] RST_FIRST_DATA    = 16'd2;
    localparam logic [3:0]  RST_CLUSTER_SHIFT = 4'd9;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] chain_head;
        logic [23:0] old_size;
        logic [23:0] new_size;
    } t_req;

    typedef struct packed {
        logic [15:0] value;
        logic        error_code;
    } t_rsp;

endpackage

### design/fat_cluster_chain_manager.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_manager - FAT16 style cluster chain allocator
// Link table in a single-port-write RAM, driven by a small sequencer that
// walks chains and searches free entries one table entry per cycle.
// ----------------------------------------------------------------------------
// After reset the table is swept to zero, one entry a cycle; requests are
// stalled meanwhile (register writes are taken). One request is worked at a
// time and the next one is taken once its response is registered. Every
// table read goes through the one RAM read port, so the cost is set by how
// many entries a request touches: a read touches the head entry, allocate
// scans entries from first_data_cluster, free or truncate walk the chain,
// resize walks the chain and then, for a grow, per appended cluster runs a
// fresh free search from first_data_cluster and links the cluster found.
// A request with no valid chain head goes straight to its response.
module fat_cluster_chain_manager #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_stall,
    input  fccm_pkg::t_req                  i_req,
    output logic                            o_rsp_valid,
    input  logic                            i_rsp_stall,
    output fccm_pkg::t_rsp                  o_rsp,
    input  logic                            i_cfg_we,
    input  logic [fccm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [15:0]                     i_cfg_data
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam logic [16:0]      TBL_LIM = 17'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(TABLE_ENTRIES);
    localparam logic [23:0]      SZ_LIM  = 24'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_RD_DATA, S_SEARCH, S_CALC, S_CMP, S_WALK,
        S_FREE, S_TRUNC_W, S_GROW_CHK, S_GROW_LINK, S_FIN
    } t_state;

    function automatic logic in_tbl(input logic [15:0] x);
        return {1'b0, x} < TBL_LIM;
    endfunction

    function automatic logic [23:0] clusters_for(input logic [23:0] b,
                                                 input logic [3:0] sh);
        logic [23:0] q;
        logic        rem;
        logic [23:0] n;
        q   = b >> sh;
        rem = (b & ((24'd1 << sh) - 24'd1)) != 24'd0;
        n   = q + {23'd0, rem};
        return (n == 24'd0) ? 24'd1 : n;
    endfunction

    // table RAM
    logic [15:0] mem [TABLE_ENTRIES];
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [15:0]      mem_wr_data;
    logic [15:0]      r_rd_data;
    logic             r_fwd_hit;
    logic [15:0]      r_fwd_data;
    logic [15:0]      rd_eff;

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= mem[mem_rd_addr];
        end
        // read of an entry written in the same cycle sees the new value
        r_fwd_hit  <= mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr);
        r_fwd_data <= mem_wr_data;
    end

    assign rd_eff = r_fwd_hit ? r_fwd_data : r_rd_data;

    // sequencer state
    t_state           r_state, n_state;
    logic [2:0]       r_op, n_op;
    logic [15:0]      r_head, n_head;
    logic [23:0]      r_old_sz, n_old_sz;
    logic [23:0]      r_new_sz, n_new_sz;
    logic [23:0]      r_new_n, n_new_n;
    logic [23:0]      r_old_n, n_old_n;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [15:0]      r_it, n_it;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_lim, n_lim;
    logic [CNT_W-1:0] r_add, n_add;
    logic             r_grow, n_grow;
    logic [CNT_W-1:0] r_scan, n_scan;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_addr, n_pend_addr;
    logic             r_first, n_first;
    logic [15:0]      r_val, n_val;
    logic             r_err, n_err;

    logic [15:0]      r_end_marker;
    logic [15:0]      r_first_dc;
    logic [3:0]       r_cl_shift;
    logic             r_out_valid;
    fccm_pkg::t_rsp   r_out;

    logic [CNT_W-1:0] scan_start;
    logic             accept;
    logic             out_load;
    logic [15:0]      f_cur;
    logic [23:0]      d_sub;
    logic [CNT_W-1:0] d_sat;

    assign scan_start = in_tbl(r_first_dc) ? CNT_W'(IDX_W'(r_first_dc)) : CNT_LIM;
    assign accept     = i_req_valid && !o_req_stall;
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || !i_rsp_stall);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_head      = r_head;
        n_old_sz    = r_old_sz;
        n_new_sz    = r_new_sz;
        n_new_n     = r_new_n;
        n_old_n     = r_old_n;
        n_cur       = r_cur;
        n_it        = r_it;
        n_cnt       = r_cnt;
        n_lim       = r_lim;
        n_add       = r_add;
        n_grow      = r_grow;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_first     = r_first;
        n_val       = r_val;
        n_err       = r_err;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_cur;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_cur;
        mem_wr_data = 16'd0;
        f_cur       = r_first ? r_it : rd_eff;
        d_sub       = r_new_n - ((r_new_n < r_old_n) ? 24'd1 : r_old_n);
        d_sat       = (d_sub > SZ_LIM) ? CNT_LIM : CNT_W'(d_sub);

        case (r_state)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = IDX_W'(r_cnt);
                if (r_cnt == CNT_LIM - CNT_W'(1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_req.req_type;
                    n_head   = i_req.chain_head;
                    n_old_sz = i_req.old_size;
                    n_new_sz = i_req.new_size;
                    n_val    = 16'd0;
                    n_err    = 1'b0;
                    n_cur    = IDX_W'(i_req.chain_head);
                    n_it     = i_req.chain_head;
                    n_cnt    = '0;
                    n_first  = 1'b1;
                    n_scan   = scan_start;
                    n_pend   = 1'b0;
                    n_state  = S_FIN;
                    case (i_req.req_type)
                        fccm_pkg::REQ_READ: begin
                            if (in_tbl(i_req.chain_head)) begin
                                n_state = S_RD;
                            end
                        end
                        fccm_pkg::REQ_ALLOC: begin
                            n_state = S_SEARCH;
                        end
                        fccm_pkg::REQ_RESIZE: begin
                            if (i_req.chain_head != 16'd0 && in_tbl(i_req.chain_head)) begin
                                n_state = S_CALC;
                            end
                        end
                        fccm_pkg::REQ_FREE, fccm_pkg::REQ_TRUNCATE: begin
                            if (i_req.chain_head != 16'd0 && in_tbl(i_req.chain_head)) begin
                                n_state = S_FREE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = IDX_W'(r_head);
                n_state     = S_RD_DATA;
            end
            S_RD_DATA: begin
                n_val   = rd_eff;
                n_state = S_FIN;
            end
            S_SEARCH: begin
                n_pend = 1'b0;
                if (r_pend && rd_eff == 16'd0) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_pend_addr;
                    mem_wr_data = r_end_marker;
                    if (r_op == fccm_pkg::REQ_ALLOC) begin
                        n_val   = 16'(r_pend_addr);
                        n_state = S_FIN;
                    end else begin
                        n_state = S_GROW_LINK;
                    end
                end else if (r_scan < CNT_LIM) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IDX_W'(r_scan);
                    n_pend      = 1'b1;
                    n_pend_addr = IDX_W'(r_scan);
                    n_scan      = r_scan + CNT_W'(1);
                end else begin
                    n_err   = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_CALC: begin
                n_new_n = clusters_for(r_new_sz, r_cl_shift);
                n_old_n = clusters_for(r_old_sz, r_cl_shift);
                n_state = S_CMP;
            end
            S_CMP: begin
                n_first = 1'b1;
                n_cnt   = '0;
                if (r_new_n == r_old_n) begin
                    n_state = S_FIN;
                end else if (r_new_n < r_old_n) begin
                    n_grow  = 1'b0;
                    n_lim   = d_sat;
                    n_state = S_WALK;
                end else begin
                    n_grow  = 1'b1;
                    n_lim   = CNT_LIM;
                    n_add   = d_sat;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_first) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_cur;
                    n_first     = 1'b0;
                end else if (rd_eff != r_end_marker && in_tbl(rd_eff) && r_cnt < r_lim) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IDX_W'(rd_eff);
                    n_cur       = IDX_W'(rd_eff);
                    n_cnt       = r_cnt + CNT_W'(1);
                end else if (r_grow) begin
                    n_cnt   = '0;
                    n_state = S_GROW_CHK;
                end else begin
                    // cut the chain here, then free what hung off it
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_cur;
                    mem_wr_data = r_end_marker;
                    n_it        = rd_eff;
                    n_first     = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_FREE;
                end
            end
            S_FREE: begin
                if (!r_first) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_cur;
                    mem_wr_data = 16'd0;
                end
                if (f_cur != r_end_marker && in_tbl(f_cur) && r_cnt < CNT_LIM) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = IDX_W'(f_cur);
                    n_cur       = IDX_W'(f_cur);
                    n_cnt       = r_cnt + CNT_W'(1);
                    n_first     = 1'b0;
                end else if (r_op == fccm_pkg::REQ_TRUNCATE) begin
                    n_state = S_TRUNC_W;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_TRUNC_W: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = IDX_W'(r_head);
                mem_wr_data = r_end_marker;
                n_state     = S_FIN;
            end
            S_GROW_CHK: begin
                if (r_cnt < r_add) begin
                    n_scan  = scan_start;
                    n_pend  = 1'b0;
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_GROW_LINK: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_cur;
                mem_wr_data = 16'(r_pend_addr);
                n_cur       = r_pend_addr;
                n_cnt       = r_cnt + CNT_W'(1);
                n_state     = S_GROW_CHK;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cnt        <= '0;
            r_first      <= 1'b1;
            r_pend       <= 1'b0;
            r_grow       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_end_marker <= fccm_pkg::RST_END_MARKER;
            r_first_dc   <= fccm_pkg::RST_FIRST_DATA;
            r_cl_shift   <= fccm_pkg::RST_CLUSTER_SHIFT;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_first <= n_first;
            r_pend  <= n_pend;
            r_grow  <= n_grow;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fccm_pkg::CFG_END_MARKER:    r_end_marker <= i_cfg_data;
                    fccm_pkg::CFG_FIRST_DATA:    r_first_dc   <= i_cfg_data;
                    fccm_pkg::CFG_CLUSTER_SHIFT: r_cl_shift   <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
        r_op        <= n_op;
        r_head      <= n_head;
        r_old_sz    <= n_old_sz;
        r_new_sz    <= n_new_sz;
        r_new_n     <= n_new_n;
        r_old_n     <= n_old_n;
        r_cur       <= n_cur;
        r_it        <= n_it;
        r_lim       <= n_lim;
        r_add       <= n_add;
        r_scan      <= n_scan;
        r_pend_addr <= n_pend_addr;
        r_val       <= n_val;
        r_err       <= n_err;
        if (out_load) begin
            r_out.value      <= r_val;
            r_out.error_code <= r_err;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // a response only leaves from the finish state
    a_rsp_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state) == S_FIN)
        else $error("response raised outside finish state");

    // a taken request always starts work
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("request taken but sequencer stayed idle");

    // a free hit never lies below the first data cluster
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && r_pend && rd_eff == 16'd0)
            |-> 16'(r_pend_addr) >= r_first_dc)
        else $error("free search returned entry below data start");

    // walk and free counters stay within the table depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE || r_state == S_WALK) |-> r_cnt <= CNT_LIM)
        else $error("chain step counter ran past table depth");

endmodule
